// ===== hdl/burst_frequency_time_clusterer_macros.svh =====
// ----------------------------------------------------------------------------
// Burst clusterer assertion macros
// Shared concurrent assertion forms used by the clusterer checker.
// ----------------------------------------------------------------------------
`ifndef BURST_FREQUENCY_TIME_CLUSTERER_MACROS_SVH
`define BURST_FREQUENCY_TIME_CLUSTERER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFC_ASSERT_IMP(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFC_ASSERT_NXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/bfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Burst clusterer package
// Types, constants and codes shared by the clusterer modules.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int SLOTS           = 8;
  localparam int SLOT_W          = 3;
  localparam int FRAMES_PER_SLOT = 2048;
  localparam int CNT_W           = 12;
  localparam int FIDX_W          = 11;
  localparam int SUM_W           = 43;
  localparam int TIME_W          = 64;
  localparam int FREQ_W          = 32;
  localparam int TOL_W           = 24;
  localparam int GAP_W           = 40;
  localparam int CFG_W           = 40;
  localparam int CFG_IDX_W       = 2;
  localparam int DIV_CNT_W       = 6;
  localparam int TGOOD_W         = 19;
  localparam int TFAIR_W         = 20;
  localparam int LIM_W           = 40;
  localparam int NS_PER_MS       = 1000000;

  localparam logic [CFG_IDX_W-1:0] REG_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN = 2'd2;

  localparam logic [1:0] KIND_STORED = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_CLOSED = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] QUAL_POOR = 2'd0;
  localparam logic [1:0] QUAL_FAIR = 2'd1;
  localparam logic [1:0] QUAL_GOOD = 2'd2;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] timestamp_ns;
    logic [FREQ_W-1:0] frequency_hz;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        slot;
    logic [FIDX_W-1:0] frame_index;
    logic [TIME_W-1:0] call_start_ns;
    logic [TIME_W-1:0] call_end_ns;
    logic [FREQ_W-1:0] mean_frequency_hz;
    logic [CNT_W-1:0]  frame_total;
    logic [31:0]       call_serial;
    logic [1:0]        quality;
    logic              last;
  } out_t;

  typedef enum logic [2:0] {
    CELL_NOP, CELL_ALLOC, CELL_STORE, CELL_TOUCH, CELL_CLEAR, CELL_MEAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] ts;
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] mean;
  } cell_cmd_t;

  typedef struct packed {
    logic              active;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] last;
    logic [FREQ_W-1:0] mean;
  } cell_status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MATCH, ST_GAP, ST_FREE, ST_EVICT, ST_CLOSE_A, ST_CLOSE_B,
    ST_CLOSE_C, ST_ALLOC, ST_ADD, ST_EMIT, ST_DIV_LOAD, ST_DIV_RUN,
    ST_FLUSH_SCAN, ST_FLUSH_NEXT, ST_FLUSH_DONE
  } state_t;

endpackage

// ===== hdl/burst_frequency_time_clusterer.sv =====
// ----------------------------------------------------------------------------
// Burst frequency/time clusterer
// Groups timestamped frames into open call slots and reports closed calls.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A frame is matched against the open
// slots, then checked against the gap or given a free slot, then added and
// reported; a stored frame then has the mean divider loaded and run after the
// frame result. Starting a new slot adds an allocation state. Closing a slot
// passes through ST_CLOSE_A, ST_CLOSE_B and ST_CLOSE_C, plus its transfer when
// the call is reported. An eviction also adds a scan over every slot. A frame
// that finds its slot full skips the divider. A flush scans each slot, closes
// every active slot, then gives the done result. Each result also waits for
// its transfer on the output.
module burst_frequency_time_clusterer import bfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t state, state_next, ret_state;

  logic [TOL_W-1:0]  tol;
  logic [GAP_W-1:0]  gap;
  logic [CNT_W-1:0]  min_frames;
  logic [31:0]       serial;

  logic [TIME_W-1:0] ts_q;
  logic [FREQ_W-1:0] freq_q;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] best_idx;
  logic [TIME_W-1:0] best_time;
  out_t              res;

  logic              c_report;
  logic [CNT_W-1:0]  c_count;
  logic [TIME_W-1:0] c_first;
  logic [TIME_W-1:0] c_last;
  logic [FREQ_W-1:0] c_mean;
  logic [TIME_W-1:0] c_dur;
  logic [TGOOD_W-1:0] t_good;
  logic [TFAIR_W-1:0] t_fair;
  logic [LIM_W-1:0]  lim_good;
  logic [LIM_W-1:0]  lim_fair;
  logic [1:0]        qual;

  cell_cmd_t         cmd;
  cell_status_t      status [SLOTS];
  cell_status_t      sel_st;
  logic [SLOTS:0]    found;
  logic [SLOTS:0]    free;
  logic [SLOTS-1:0]  take;
  logic [SLOTS-1:0]  free_take;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;
  logic              stored;
  logic              gap_over;
  logic              take_best;
  logic [21:0]       n900;

  logic              div_start;
  logic              div_done;
  logic [FREQ_W-1:0] div_q;

  assign found[0] = 1'b0;
  assign free[0]  = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    bfc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .sel      (idx == SLOT_W'(i)),
      .cmd      (cmd),
      .tol      (tol),
      .found_in (found[i]),
      .free_in  (free[i]),
      .found_out(found[i+1]),
      .free_out (free[i+1]),
      .take     (take[i]),
      .free_take(free_take[i]),
      .status   (status[i])
    );
  end

  bfc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sel_st.sum),
    .divisor (sel_st.count),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (take[i]) hit_idx = SLOT_W'(i);
      if (free_take[i]) free_idx = SLOT_W'(i);
    end
  end

  always_comb begin
    sel_st    = status[idx];
    stored    = sel_st.count < CNT_W'(FRAMES_PER_SLOT);
    gap_over  = (ts_q - sel_st.last) > {{(TIME_W-GAP_W){1'b0}}, gap};
    take_best = (idx == '0) || (sel_st.first < best_time);
    n900      = 22'(sel_st.count) * 22'd900;
    if (c_dur < TIME_W'(NS_PER_MS)) qual = QUAL_POOR;
    else if (c_dur < {{(TIME_W-LIM_W){1'b0}}, lim_good}) qual = QUAL_GOOD;
    else if (c_dur < {{(TIME_W-LIM_W){1'b0}}, lim_fair}) qual = QUAL_FAIR;
    else qual = QUAL_POOR;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_valid) state_next = in_data.action ? ST_FLUSH_SCAN : ST_MATCH;
      ST_MATCH:      state_next = found[SLOTS] ? ST_GAP : ST_FREE;
      ST_GAP:        state_next = gap_over ? ST_CLOSE_A : ST_ADD;
      ST_FREE:       state_next = free[SLOTS] ? ST_ALLOC : ST_EVICT;
      ST_EVICT:      if (idx == SLOT_W'(SLOTS - 1)) state_next = ST_CLOSE_A;
      ST_CLOSE_A:    state_next = ST_CLOSE_B;
      ST_CLOSE_B:    state_next = ST_CLOSE_C;
      ST_CLOSE_C:    state_next = c_report ? ST_EMIT : ret_state;
      ST_ALLOC:      state_next = ST_ADD;
      ST_ADD:        state_next = ST_EMIT;
      ST_EMIT:       if (out_ready) state_next = ret_state;
      ST_DIV_LOAD:   state_next = ST_DIV_RUN;
      ST_DIV_RUN:    if (div_done) state_next = ST_IDLE;
      ST_FLUSH_SCAN: state_next = sel_st.active ? ST_CLOSE_A : ST_FLUSH_NEXT;
      ST_FLUSH_NEXT: state_next = (idx == SLOT_W'(SLOTS - 1)) ? ST_FLUSH_DONE : ST_FLUSH_SCAN;
      ST_FLUSH_DONE: state_next = ST_EMIT;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Outputs and cell commands.
  always_comb begin
    in_ready  = state == ST_IDLE;
    div_start = state == ST_DIV_LOAD;
    cmd.ts    = ts_q;
    cmd.freq  = freq_q;
    cmd.mean  = div_q;
    case (state)
      ST_ALLOC:   cmd.op = CELL_ALLOC;
      ST_ADD:     cmd.op = stored ? CELL_STORE : CELL_TOUCH;
      ST_CLOSE_C: cmd.op = CELL_CLEAR;
      ST_DIV_RUN: cmd.op = div_done ? CELL_MEAN : CELL_NOP;
      default:    cmd.op = CELL_NOP;
    endcase
  end

  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret_state  <= ST_IDLE;
      out_valid  <= 1'b0;
      serial     <= '0;
      tol        <= TOL_W'(20000);
      gap        <= GAP_W'(1000000000);
      min_frames <= CNT_W'(3);
      idx        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_TOL: tol        <= cfg_data[TOL_W-1:0];
          REG_GAP: gap        <= cfg_data[GAP_W-1:0];
          REG_MIN: min_frames <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ts_q     <= in_data.timestamp_ns;
            freq_q   <= in_data.frequency_hz;
            idx      <= '0;
          end
        end
        ST_MATCH: idx <= hit_idx;
        ST_GAP:   ret_state <= ST_FREE;
        ST_FREE:  idx <= free[SLOTS] ? free_idx : '0;
        ST_EVICT: begin
          // The earliest start wins; on a tie the lower slot is kept.
          if (take_best) begin
            best_idx  <= idx;
            best_time <= sel_st.first;
          end
          if (idx == SLOT_W'(SLOTS - 1)) begin
            idx       <= take_best ? idx : best_idx;
            ret_state <= ST_ALLOC;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end
        ST_CLOSE_A: begin
          c_report <= sel_st.active && (sel_st.count >= min_frames);
          c_count  <= sel_st.count;
          c_first  <= sel_st.first;
          c_last   <= sel_st.last;
          c_mean   <= sel_st.mean;
          c_dur    <= sel_st.last - sel_st.first;
          t_fair   <= TFAIR_W'(sel_st.count) * TFAIR_W'(180);
          t_good   <= (sel_st.count == '0) ? '0
                      : TGOOD_W'((n900 - 22'd1) >> 3) + TGOOD_W'(1);
        end
        ST_CLOSE_B: begin
          lim_good <= LIM_W'(t_good) * LIM_W'(NS_PER_MS);
          lim_fair <= LIM_W'(t_fair) * LIM_W'(NS_PER_MS);
        end
        ST_CLOSE_C: begin
          res                   <= '0;
          res.kind              <= KIND_CLOSED;
          res.slot              <= idx;
          res.call_start_ns     <= c_first;
          res.call_end_ns       <= c_last;
          res.mean_frequency_hz <= c_mean;
          res.frame_total       <= c_count;
          res.call_serial       <= serial;
          res.quality           <= qual;
          out_valid             <= c_report;
          if (c_report) serial <= serial + 32'd1;
        end
        ST_ADD: begin
          res             <= '0;
          res.kind        <= stored ? KIND_STORED : KIND_FULL;
          res.slot        <= idx;
          res.frame_index <= stored ? sel_st.count[FIDX_W-1:0] : '0;
          res.last        <= 1'b1;
          out_valid       <= 1'b1;
          ret_state       <= stored ? ST_DIV_LOAD : ST_IDLE;
        end
        ST_EMIT: if (out_ready) out_valid <= 1'b0;
        ST_FLUSH_SCAN: if (sel_st.active) ret_state <= ST_FLUSH_NEXT;
        ST_FLUSH_NEXT: if (idx != SLOT_W'(SLOTS - 1)) idx <= idx + SLOT_W'(1);
        ST_FLUSH_DONE: begin
          res       <= '0;
          res.kind  <= KIND_DONE;
          res.last  <= 1'b1;
          out_valid <= 1'b1;
          ret_state <= ST_IDLE;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/bfc_cell.sv =====
// ----------------------------------------------------------------------------
// Burst clusterer slot cell
// Holds one call slot, tests a frame against its mean and passes the
// first-match and first-free chains on to the next cell.
// ----------------------------------------------------------------------------
module bfc_cell import bfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             sel,
  input  cell_cmd_t        cmd,
  input  logic [TOL_W-1:0] tol,
  input  logic             found_in,
  input  logic             free_in,
  output logic             found_out,
  output logic             free_out,
  output logic             take,
  output logic             free_take,
  output cell_status_t     status
);

  logic              active;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [TIME_W-1:0] first;
  logic [TIME_W-1:0] last;
  logic [FREQ_W-1:0] mean;
  logic [FREQ_W-1:0] diff;
  logic              is_match;

  always_comb begin
    diff      = (cmd.freq >= mean) ? cmd.freq - mean : mean - cmd.freq;
    is_match  = active && (diff <= {{(FREQ_W-TOL_W){1'b0}}, tol});
    take      = is_match && !found_in;
    found_out = found_in || is_match;
    free_take = !active && !free_in;
    free_out  = free_in || !active;
  end

  assign status = '{active: active, count: count, sum: sum, first: first,
                    last: last, mean: mean};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
      sum    <= '0;
      first  <= '0;
      last   <= '0;
      mean   <= '0;
    end else if (sel) begin
      case (cmd.op)
        CELL_ALLOC: begin
          active <= 1'b1;
          count  <= '0;
          sum    <= '0;
          mean   <= '0;
          first  <= cmd.ts;
        end
        CELL_STORE: begin
          count <= count + CNT_W'(1);
          sum   <= sum + {{(SUM_W-FREQ_W){1'b0}}, cmd.freq};
          last  <= cmd.ts;
        end
        CELL_TOUCH: last <= cmd.ts;
        CELL_CLEAR: begin
          active <= 1'b0;
          count  <= '0;
          sum    <= '0;
          mean   <= '0;
        end
        CELL_MEAN: mean <= cmd.mean;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/bfc_div.sv =====
// ----------------------------------------------------------------------------
// Burst clusterer mean divider
// Restoring divider, one quotient bit per cycle, for frequency sum / count.
// ----------------------------------------------------------------------------
module bfc_div import bfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [FREQ_W-1:0] quotient
);

  logic [CNT_W:0]     rem;
  logic [SUM_W-1:0]   quo;
  logic [CNT_W-1:0]   dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic               busy;
  logic [CNT_W:0]     shifted;
  logic               fits;

  always_comb begin
    shifted = {rem[CNT_W-1:0], quo[SUM_W-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  assign quotient = quo[FREQ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= DIV_CNT_W'(SUM_W);
      end else if (busy) begin
        rem <= fits ? shifted - {1'b0, dvs} : shifted;
        quo <= {quo[SUM_W-2:0], fits};
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/bfc_checker.sv =====
// ----------------------------------------------------------------------------
// Burst clusterer port checker
// Watches the top-level handshakes and result framing over time.
// ----------------------------------------------------------------------------
`include "burst_frequency_time_clusterer_macros.svh"

module bfc_checker import bfc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A result held back by the consumer must not change.
  `BFC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Only one item is worked on at a time.
  `BFC_ASSERT_NXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "input taken while busy")

  // Results only appear while an item is in progress.
  `BFC_ASSERT_IMP(a_out_busy, clk, rst, out_valid, !in_ready, "result shown while idle")

  // A frame result or a flush done ends its item; a closed call never does.
  `BFC_ASSERT_IMP(a_last_kind, clk, rst, out_valid, out_data.last == (out_data.kind != KIND_CLOSED), "last flag does not match result kind")

endmodule

bind burst_frequency_time_clusterer bfc_checker u_bfc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Burst clusterer testbench
// Drives frames and flushes through the clusterer under random idling on both
// sides, predicts every slot, close and flush result from its own copy of the
// slot state and compares each output transfer field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import bfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 100;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  burst_frequency_time_clusterer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the clusterer: registers and per-slot state.
  logic [TOL_W-1:0]  tol_hz;
  logic [GAP_W-1:0]  gap_ns;
  logic [CNT_W-1:0]  min_count;
  logic              open_slot [SLOTS];
  logic [CNT_W-1:0]  frames_in [SLOTS];
  logic [63:0]       freq_total [SLOTS];
  logic [63:0]       start_ts [SLOTS];
  logic [63:0]       latest_ts [SLOTS];
  logic [31:0]       next_serial;

  in_t  frame_queue [$];
  out_t due_results [$];
  bit   failed;
  bit   tx_calm, rx_calm;
  int   tx_wait, rx_wait, quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] slot_mean(int s);
    if (frames_in[s] == 0) return 64'd0;
    return freq_total[s] / frames_in[s];
  endfunction

  function automatic logic [1:0] grade_call(logic [CNT_W-1:0] n, logic [63:0] t0,
                                            logic [63:0] t1);
    logic [63:0] ms;
    ms = (t1 - t0) / NS_PER_MS;
    if (ms == 0) return QUAL_POOR;
    if (64'(900) * n > 64'(8) * ms) return QUAL_GOOD;
    if (64'(180) * n > ms) return QUAL_FAIR;
    return QUAL_POOR;
  endfunction

  task automatic push_result(logic [1:0] kind, int s, logic [FIDX_W-1:0] fidx,
                             logic [63:0] t0, logic [63:0] t1, logic [31:0] mean,
                             logic [CNT_W-1:0] total, logic [31:0] serial,
                             logic [1:0] qual);
    out_t r;
    r = '0;
    r.kind = kind;
    r.slot = s[2:0];
    r.frame_index = fidx;
    r.call_start_ns = t0;
    r.call_end_ns = t1;
    r.mean_frequency_hz = mean;
    r.frame_total = total;
    r.call_serial = serial;
    r.quality = qual;
    due_results.push_back(r);
  endtask

  task automatic close_call(int s);
    if (open_slot[s] && frames_in[s] >= min_count) begin
      push_result(KIND_CLOSED, s, '0, start_ts[s], latest_ts[s], 32'(slot_mean(s)),
                  frames_in[s], next_serial,
                  grade_call(frames_in[s], start_ts[s], latest_ts[s]));
      next_serial++;
    end
    open_slot[s] = 1'b0;
    frames_in[s] = '0;
    freq_total[s] = '0;
  endtask

  task automatic cluster_frame(in_t it);
    int hit;
    logic [63:0] m, df, f;
    out_t r;
    hit = -1;
    f = 64'(it.frequency_hz);
    if (it.action) begin
      for (int s = 0; s < SLOTS; s++)
        if (open_slot[s]) close_call(s);
      push_result(KIND_DONE, 0, '0, '0, '0, '0, '0, '0, QUAL_POOR);
    end else begin
      for (int s = 0; s < SLOTS; s++) begin
        if (open_slot[s] && hit < 0) begin
          m = slot_mean(s);
          df = (f >= m) ? f - m : m - f;
          if (df <= 64'(tol_hz)) hit = s;
        end
      end
      if (hit >= 0 && it.timestamp_ns - latest_ts[hit] > 64'(gap_ns)) begin
        close_call(hit);
        hit = -1;
      end
      if (hit < 0) begin
        for (int s = SLOTS - 1; s >= 0; s--)
          if (!open_slot[s]) hit = s;
        if (hit < 0) begin
          hit = 0;
          for (int s = 1; s < SLOTS; s++)
            if (start_ts[s] < start_ts[hit]) hit = s;
          close_call(hit);
        end
        open_slot[hit] = 1'b1;
        frames_in[hit] = '0;
        freq_total[hit] = '0;
        start_ts[hit] = it.timestamp_ns;
      end
      if (frames_in[hit] < FRAMES_PER_SLOT) begin
        push_result(KIND_STORED, hit, frames_in[hit][FIDX_W-1:0], '0, '0, '0, '0, '0,
                    QUAL_POOR);
        frames_in[hit] = frames_in[hit] + 1'b1;
        freq_total[hit] = freq_total[hit] + f;
      end else begin
        push_result(KIND_FULL, hit, '0, '0, '0, '0, '0, '0, QUAL_POOR);
      end
      latest_ts[hit] = it.timestamp_ns;
    end
    r = due_results.pop_back();
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  function automatic int draw_wait(ref bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Driver: a new item is loaded only once the previous transfer is done.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) cluster_frame(in_data);
      if (!(in_valid && !in_ready)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (frame_queue.size() > 0) begin
          in_data <= frame_queue.pop_front();
          in_valid <= 1'b1;
          tx_wait = draw_wait(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Monitor: compares each output transfer with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          failed = 1'b1;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("slot", want.slot, out_data.slot);
          check_field("frame_index", want.frame_index, out_data.frame_index);
          check_field("call_start_ns", want.call_start_ns, out_data.call_start_ns);
          check_field("call_end_ns", want.call_end_ns, out_data.call_end_ns);
          check_field("mean_frequency_hz", want.mean_frequency_hz,
                      out_data.mean_frequency_hz);
          check_field("frame_total", want.frame_total, out_data.frame_total);
          check_field("call_serial", want.call_serial, out_data.call_serial);
          check_field("quality", want.quality, out_data.quality);
          check_field("last", want.last, out_data.last);
        end
        rx_wait = draw_wait(rx_calm);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_frame(logic [63:0] ts, logic [31:0] freq);
    in_t it;
    it.action = 1'b0;
    it.timestamp_ns = ts;
    it.frequency_hz = freq;
    frame_queue.push_back(it);
  endtask

  task automatic add_flush();
    in_t it;
    it.action = 1'b1;
    it.timestamp_ns = {$urandom, $urandom};
    it.frequency_hz = $urandom;
    frame_queue.push_back(it);
  endtask

  task automatic wait_drained();
    while (frame_queue.size() > 0 || in_valid || due_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_TOL: tol_hz = value[TOL_W-1:0];
      REG_GAP: gap_ns = value[GAP_W-1:0];
      REG_MIN: min_count = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] tol, logic [CFG_W-1:0] gap,
                           logic [CFG_W-1:0] minf);
    write_reg(REG_TOL, tol);
    write_reg(REG_GAP, gap);
    write_reg(REG_MIN, minf);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Frames mostly gather around a dozen carriers, with some noise and flushes.
  task automatic random_traffic(int count);
    logic [31:0] carrier [12];
    logic [63:0] now;
    int k, jit;
    now = {$urandom, $urandom};
    for (int i = 0; i < 12; i++) carrier[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 5) begin
        add_flush();
      end else if (k < 15) begin
        add_frame({$urandom, $urandom}, $urandom);
      end else begin
        if ($urandom_range(0, 19) == 0)
          now += 64'(gap_ns) + 64'($urandom_range(1, 100000));
        else
          now += 64'($urandom_range(0, 200)) * NS_PER_MS + 64'($urandom_range(0, 999999));
        jit = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 30000) - 15000;
        add_frame(now, carrier[$urandom_range(0, 11)] + jit);
      end
    end
    add_flush();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failed = 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    tx_wait = 0;
    rx_wait = 0;
    tol_hz = 24'd20000;
    gap_ns = 40'd1000000000;
    min_count = 12'd3;
    next_serial = '0;
    for (int s = 0; s < SLOTS; s++) begin
      open_slot[s] = 1'b0;
      frames_in[s] = '0;
      freq_total[s] = '0;
      start_ts[s] = '0;
      latest_ts[s] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty flush, field extremes, gap close, eviction with tied starts.
    add_flush();
    add_frame(64'd0, 32'd0);
    add_frame(64'd1000000, 32'd10);
    add_frame(64'd2000000, 32'd0);
    add_frame(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    add_frame(64'd5000000000, 32'd5);
    add_flush();
    for (int i = 0; i < 9; i++) add_frame(64'd7000000000, 32'd100000000 * (i + 1));
    add_frame(64'd7050000000, 32'd100000000);
    add_flush();
    wait_drained();

    // Register extremes and random settings; the unused index is also written.
    configure(0, 40'hFF_FFFF_FFFF, 1);
    write_reg(2'd3, {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
    random_traffic(45);
    wait_drained();
    configure(24'hFF_FFFF, 0, 5);
    random_traffic(45);
    wait_drained();
    configure(20000, 1000000000, 2);
    random_traffic(45);
    wait_drained();
    configure($urandom_range(0, 50000), $urandom_range(100000000, 2000000000),
              $urandom_range(1, 6));
    random_traffic(45);
    wait_drained();
    configure(5000, 300000000, 3);
    random_traffic(45);
    wait_drained();
    configure($urandom_range(0, 30000), {$urandom, $urandom}, $urandom_range(1, 4));
    random_traffic(45);
    wait_drained();

    if (!failed) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bfc_pkg.sv
hdl/bfc_cell.sv
hdl/bfc_div.sv
hdl/burst_frequency_time_clusterer.sv
hdl/bfc_checker.sv
tb/testbench.sv
